// ----- rtl/core/tga_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tga_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes.
    localparam logic ERR_BAD_DEPTH = 1'b0;
    localparam logic ERR_BAD_TYPE  = 1'b1;

    // Image types that are decoded.
    localparam logic [7:0] TYPE_RAW_TRUECOLOR = 8'd2;
    localparam logic [7:0] TYPE_RLE_TRUECOLOR = 8'd10;

    // Pixel depths in bits and the matching byte counts.
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;
    localparam logic [2:0] BPP_NONE = 3'd0;
    localparam logic [2:0] BPP_3    = 3'd3;
    localparam logic [2:0] BPP_4    = 3'd4;

    // Header byte offsets.
    localparam logic [4:0] HDR_ID_LEN   = 5'd0;
    localparam logic [4:0] HDR_TYPE     = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH    = 5'd16;
    localparam logic [4:0] HDR_DESC     = 5'd17;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_SKIP   = 5'b00010,
        PH_PACKET = 5'b00100,
        PH_PIXEL  = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } tga_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] width_px;
        logic [15:0] height_px;
        logic        top_down;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  repeat_count;
        logic        last_pixel;
        logic        error_code;
    } tga_out_t;

endpackage

`default_nettype wire

// ----- rtl/core/tga_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Byte parser: holds the decode state and works out, for each accepted
// byte, the next state and the result (if any) that the byte produces.
module tga_parser import tga_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     step_en,
    input  wire tga_in_t  in_item,
    output logic          res_valid,
    output tga_out_t      res_item
);

    phase_t      phase_reg, phase_next;
    logic [4:0]  hdr_pos_reg, hdr_pos_next;
    logic [7:0]  id_skip_reg, id_skip_next;
    logic [7:0]  img_type_reg, img_type_next;
    logic [2:0]  bpp_reg, bpp_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  desc_reg, desc_next;
    logic [31:0] pix_left_reg, pix_left_next;
    logic [7:0]  pkt_left_reg, pkt_left_next;
    logic        pkt_run_reg, pkt_run_next;
    logic [1:0]  byte_idx_reg, byte_idx_next;
    logic [31:0] gather_reg, gather_next;

    phase_t      cur_phase;
    logic [4:0]  cur_pos;
    logic [7:0]  b;
    logic        is_rle;
    logic [7:0]  rep;
    logic [31:0] gathered;
    phase_t      data_phase;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            hdr_pos_reg  <= '0;
            id_skip_reg  <= '0;
            img_type_reg <= '0;
            bpp_reg      <= BPP_NONE;
            width_reg    <= '0;
            height_reg   <= '0;
            desc_reg     <= '0;
            pix_left_reg <= '0;
            pkt_left_reg <= '0;
            pkt_run_reg  <= 1'b0;
            byte_idx_reg <= '0;
            gather_reg   <= '0;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            hdr_pos_reg  <= hdr_pos_next;
            id_skip_reg  <= id_skip_next;
            img_type_reg <= img_type_next;
            bpp_reg      <= bpp_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            desc_reg     <= desc_next;
            pix_left_reg <= pix_left_next;
            pkt_left_reg <= pkt_left_next;
            pkt_run_reg  <= pkt_run_next;
            byte_idx_reg <= byte_idx_next;
            gather_reg   <= gather_next;
        end
    end

    always_comb begin
        b         = in_item.data_byte;
        cur_phase = in_item.start_of_file ? PH_HEADER : phase_reg;
        cur_pos   = in_item.start_of_file ? 5'd0 : hdr_pos_reg;
        is_rle    = (img_type_reg == TYPE_RLE_TRUECOLOR);
        rep       = 8'd1;
        gathered  = gather_reg;

        phase_next    = cur_phase;
        hdr_pos_next  = cur_pos;
        id_skip_next  = id_skip_reg;
        img_type_next = img_type_reg;
        bpp_next      = bpp_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        desc_next     = desc_reg;
        pix_left_next = pix_left_reg;
        pkt_left_next = pkt_left_reg;
        pkt_run_next  = pkt_run_reg;
        byte_idx_next = byte_idx_reg;
        gather_next   = gather_reg;

        // Phase taken on entering pixel data, from the current pixel count.
        if (pix_left_reg == 32'd0) begin
            data_phase = PH_DONE;
        end else if (is_rle) begin
            data_phase = PH_PACKET;
        end else begin
            data_phase = PH_PIXEL;
        end

        res_valid = 1'b0;
        res_item  = '0;

        case (cur_phase)
            PH_HEADER: begin
                case (cur_pos)
                    HDR_ID_LEN:    id_skip_next = b;
                    HDR_TYPE:      img_type_next = b;
                    HDR_WIDTH_LO:  width_next = {width_reg[15:8], b};
                    HDR_WIDTH_HI:  width_next = {b, width_reg[7:0]};
                    HDR_HEIGHT_LO: height_next = {height_reg[15:8], b};
                    HDR_HEIGHT_HI: height_next = {b, height_reg[7:0]};
                    HDR_DEPTH: begin
                        if (b == DEPTH_32) begin
                            bpp_next = BPP_4;
                        end else if (b == DEPTH_24) begin
                            bpp_next = BPP_3;
                        end else begin
                            bpp_next = BPP_NONE;
                        end
                    end
                    HDR_DESC:      desc_next = b;
                    default: ;
                endcase

                if (cur_pos != HDR_DESC) begin
                    hdr_pos_next = cur_pos + 5'd1;
                end else begin
                    hdr_pos_next = '0;
                    res_valid    = 1'b1;
                    if (bpp_reg == BPP_NONE) begin
                        phase_next          = PH_DONE;
                        res_item.kind       = KIND_ERROR;
                        res_item.error_code = ERR_BAD_DEPTH;
                    end else if (img_type_reg != TYPE_RAW_TRUECOLOR &&
                                 img_type_reg != TYPE_RLE_TRUECOLOR) begin
                        phase_next          = PH_DONE;
                        res_item.kind       = KIND_ERROR;
                        res_item.error_code = ERR_BAD_TYPE;
                    end else begin
                        pix_left_next         = width_reg * height_reg;
                        res_item.kind         = KIND_HEADER;
                        res_item.width_px     = width_reg;
                        res_item.height_px    = height_reg;
                        // The descriptor is the byte arriving now.
                        res_item.top_down     = b[5];
                        res_item.last_pixel   = (width_reg == 16'd0) || (height_reg == 16'd0);
                        if (id_skip_reg != 8'd0) begin
                            phase_next = PH_SKIP;
                        end else begin
                            byte_idx_next = '0;
                            pkt_left_next = '0;
                            pkt_run_next  = 1'b0;
                            if (res_item.last_pixel) begin
                                phase_next = PH_DONE;
                            end else if (is_rle) begin
                                phase_next = PH_PACKET;
                            end else begin
                                phase_next = PH_PIXEL;
                            end
                        end
                    end
                end
            end

            PH_SKIP: begin
                if (id_skip_reg != 8'd0) begin
                    id_skip_next = id_skip_reg - 8'd1;
                end
                if (id_skip_next == 8'd0) begin
                    byte_idx_next = '0;
                    pkt_left_next = '0;
                    pkt_run_next  = 1'b0;
                    phase_next    = data_phase;
                end
            end

            PH_PACKET: begin
                rep = {1'b0, b[6:0]} + 8'd1;
                if ({24'd0, rep} > pix_left_reg) begin
                    rep = pix_left_reg[7:0];
                end
                pkt_left_next = rep;
                pkt_run_next  = b[7];
                byte_idx_next = '0;
                phase_next    = PH_PIXEL;
            end

            PH_PIXEL: begin
                if (byte_idx_reg == 2'd0) begin
                    gathered = '0;
                end
                gathered[8*byte_idx_reg +: 8] = b;
                gather_next = gathered;

                if ({1'b0, byte_idx_reg} + 3'd1 < bpp_reg) begin
                    byte_idx_next = byte_idx_reg + 2'd1;
                end else begin
                    byte_idx_next = '0;
                    if (is_rle && pkt_run_reg) begin
                        rep = pkt_left_reg;
                    end
                    if (rep == 8'd0) begin
                        rep = 8'd1;
                    end
                    if ({24'd0, rep} > pix_left_reg) begin
                        rep = pix_left_reg[7:0];
                    end
                    pix_left_next = pix_left_reg - {24'd0, rep};
                    if (is_rle) begin
                        if (pkt_run_reg || pkt_left_reg == 8'd0) begin
                            pkt_left_next = '0;
                        end else begin
                            pkt_left_next = pkt_left_reg - 8'd1;
                        end
                    end

                    res_valid             = 1'b1;
                    res_item.kind         = KIND_PIXEL;
                    res_item.red          = gathered[23:16];
                    res_item.green        = gathered[15:8];
                    res_item.blue         = gathered[7:0];
                    res_item.alpha        = (bpp_reg == BPP_4) ? gathered[31:24] : ALPHA_OPAQUE;
                    res_item.repeat_count = rep;

                    if (pix_left_next == 32'd0) begin
                        res_item.last_pixel = 1'b1;
                        phase_next          = PH_DONE;
                    end else if (is_rle && pkt_left_next == 8'd0) begin
                        phase_next = PH_PACKET;
                    end
                end
            end

            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/tga_outreg.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Result register: holds one result until the receiver takes it and
// reports whether the parser may take a byte in this cycle.
module tga_outreg import tga_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     load_en,
    input  wire tga_out_t load_item,
    output logic          space_ok,
    output logic          m_valid,
    input  wire logic     m_ready,
    output tga_out_t      m_item
);

    logic     valid_reg, valid_next;
    tga_out_t item_reg;

    // A byte may enter whenever the held result is gone or leaves this cycle.
    assign space_ok = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (load_en) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            item_reg <= load_item;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tga_rle_image_decoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// TGA image decoder, one file byte per transaction.
// Input channel (s_valid, s_ready, s_item): each transaction carries the next
// byte of the file and a start_of_file flag that restarts the parser at
// header byte 0. Result channel (m_valid, m_ready, m_item): each transaction
// carries a header result (width, height, top-down flag), a pixel result in
// RGBA with its repeat count, or an error result for an unsupported type or
// depth. A byte gives at most one result.
// A result is registered: it appears on m_item just after the rising edge
// that accepts the byte which completes it, and is held there until taken.
// Throughput: one byte per cycle. The parser state is updated by a single
// level of logic between the state registers and the result register, and
// the result register frees itself in the same cycle that the receiver takes
// its contents, so s_ready stays high while the receiver keeps m_ready high.
// When the receiver stalls with a result held, s_ready drops until that
// result is taken; bytes that give no result are also held back then.
// Reset (aresetn low at a rising edge) empties the result register and puts
// the parser in the header phase, so the first byte after reset is taken as
// header byte 0 even without start_of_file.
module tga_rle_image_decoder_top import tga_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire tga_in_t  s_item,
    output logic          m_valid,
    input  wire logic     m_ready,
    output tga_out_t      m_item
);

    logic     step_en;
    logic     res_valid;
    tga_out_t res_item;
    logic     space_ok;

    // Every accepted byte advances the parser; the result register is loaded
    // only when that byte produces a result.
    assign s_ready = space_ok;
    assign step_en = s_valid && space_ok;

    tga_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .in_item   (s_item),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    tga_outreg u_outreg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load_en   (step_en && res_valid),
        .load_item (res_item),
        .space_ok  (space_ok),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

`default_nettype wire
